// ===== rtl/core/vblur_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vblur_pkg
// Shared types, sizes and tap tables for the vertical 13-tap RGB blur.
// ----------------------------------------------------------------------------
package vblur_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	localparam int CH_W       = 16;
	localparam int CHANS      = 3;
	localparam int STORE_ROWS = 12;
	localparam int TAPS       = 13;
	localparam int EDGE_ROWS  = 6;
	localparam int EDGE_TAP0  = TAPS - EDGE_ROWS;
	localparam int GROUPS     = 3;
	localparam int GROUP_LANES = STORE_ROWS / GROUPS;

	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_HEIGHT);
	localparam int CFG_W     = 12;
	localparam int OUT_IDX_W = 11;
	localparam int TAP_W     = 4;
	localparam int CNT_W     = 3;
	localparam int EDGE_W    = 3;
	localparam int DIM_A     = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
	localparam int DIM_W     = (DIM_A > ROW_W + 1) ? DIM_A : ROW_W + 1;

	localparam int WGT_W  = 7;
	localparam int PROD_W = CH_W + WGT_W;
	localparam int ACC_W  = CH_W + 8;

	// floor(x / 246) == (x * RECIP) >> RECIP_SHIFT for every x below 2^24
	localparam int RECIP_W     = 25;
	localparam int RECIP_SHIFT = 32;
	localparam logic [RECIP_W-1:0] RECIP = 25'd17459217;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd1024;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd512;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef logic [CHANS-1:0][CH_W-1:0] pix_t;
	typedef logic [CHANS-1:0][PROD_W-1:0] prod_t;
	typedef logic [CHANS-1:0][ACC_W-1:0] acc_t;

	typedef struct packed {
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
	} in_t;

	typedef struct packed {
		logic [CH_W-1:0]      red_out;
		logic [CH_W-1:0]      green_out;
		logic [CH_W-1:0]      blue_out;
		logic [OUT_IDX_W-1:0] out_row;
		logic [OUT_IDX_W-1:0] out_col;
		logic                 run_last;
	} out_t;

	typedef struct packed {
		logic             pass;
		logic [CNT_W-1:0] count;
		logic [ROW_W-1:0] row_base;
		logic [COL_W-1:0] col;
		logic [TAP_W-1:0] phase;
	} ctrl_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	function automatic logic [WGT_W-1:0] tap_weight(input logic [TAP_W-1:0] tap);
		logic [WGT_W-1:0] w;
		case (tap)
			4'd0:    w = 7'd3;
			4'd1:    w = 7'd4;
			4'd2:    w = 7'd6;
			4'd3:    w = 7'd10;
			4'd4:    w = 7'd20;
			4'd5:    w = 7'd40;
			4'd6:    w = 7'd80;
			4'd7:    w = 7'd40;
			4'd8:    w = 7'd20;
			4'd9:    w = 7'd10;
			4'd10:   w = 7'd6;
			4'd11:   w = 7'd4;
			4'd12:   w = 7'd3;
			default: w = 7'd0;
		endcase
		return w;
	endfunction

	// bank holding tap t when the current row sits in bank phase
	function automatic logic [TAP_W-1:0] tap_bank(input logic [TAP_W-1:0] phase,
			input logic [TAP_W-1:0] tap);
		logic [TAP_W:0] s;
		s = {1'b0, phase} + {1'b0, tap};
		if (s >= (TAP_W+1)'(STORE_ROWS)) begin
			s = s - (TAP_W+1)'(STORE_ROWS);
		end
		return s[TAP_W-1:0];
	endfunction

	// tap fed by bank b
	function automatic logic [TAP_W-1:0] bank_tap(input logic [TAP_W-1:0] phase,
			input logic [TAP_W-1:0] bank);
		logic [TAP_W:0] s;
		if (bank >= phase) begin
			s = {1'b0, bank} - {1'b0, phase};
		end else begin
			s = {1'b0, bank} + (TAP_W+1)'(STORE_ROWS) - {1'b0, phase};
		end
		return s[TAP_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/vblur_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vblur_lane
// One line-store bank (one stored row) and its weighted product per channel.
// ----------------------------------------------------------------------------
module vblur_lane (
	input  wire logic                          clk,
	input  wire logic                          rd_en,
	input  wire logic                          wr_en,
	input  wire logic [vblur_pkg::COL_W-1:0]   addr,
	input  wire vblur_pkg::pix_t               wr_data,
	input  wire logic                          prod_en,
	input  wire logic [vblur_pkg::TAP_W-1:0]   tap,
	output vblur_pkg::pix_t                    rd_data_s1,
	output vblur_pkg::prod_t                   prod_s2
);

	vblur_pkg::pix_t mem [vblur_pkg::MAX_WIDTH];
	logic [vblur_pkg::WGT_W-1:0] weight;

	// read returns the old word when the same column is written
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[addr];
		end
	end

	assign weight = vblur_pkg::tap_weight(tap);

	always_ff @(posedge clk) begin
		if (prod_en) begin
			for (int ch = 0; ch < vblur_pkg::CHANS; ch++) begin
				prod_s2[ch] <= vblur_pkg::PROD_W'(rd_data_s1[ch])
					* vblur_pkg::PROD_W'(weight);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/vblur_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vblur_merge
// Sums the lane products in a registered tree, divides by the weight total
// and carries the bottom-edge pixels alongside.
// ----------------------------------------------------------------------------
module vblur_merge (
	input  wire logic                                        clk,
	input  wire vblur_pkg::pipe_en_t                         en,
	input  wire vblur_pkg::ctrl_t                            ctrl_s1,
	input  wire vblur_pkg::pix_t                             px_s1,
	input  wire vblur_pkg::pix_t [vblur_pkg::STORE_ROWS-1:0] bank_s1,
	input  wire vblur_pkg::prod_t [vblur_pkg::STORE_ROWS-1:0] prod_s2,
	output vblur_pkg::ctrl_t                                 ctrl_s5,
	output vblur_pkg::pix_t                                  filt_s5,
	output vblur_pkg::pix_t [vblur_pkg::EDGE_ROWS-1:0]       edge_s5
);

	localparam int PROD_SUM_W = vblur_pkg::ACC_W + vblur_pkg::RECIP_W;

	vblur_pkg::ctrl_t ctrl_s2, ctrl_s3, ctrl_s4;
	vblur_pkg::pix_t  px_s2;
	vblur_pkg::pix_t [vblur_pkg::EDGE_ROWS-1:0] edge_sel, edge_s2, edge_s3, edge_s4;
	vblur_pkg::acc_t [vblur_pkg::GROUPS-1:0] part_sum, part_s3;
	vblur_pkg::acc_t acc_sum, acc_s4;
	vblur_pkg::pix_t quot;

	// rows r-5..r-1 come from the stored taps, row r is the incoming pixel
	always_comb begin
		for (int k = 0; k < vblur_pkg::EDGE_ROWS - 1; k++) begin
			edge_sel[k] = bank_s1[vblur_pkg::tap_bank(ctrl_s1.phase,
				vblur_pkg::TAP_W'(vblur_pkg::EDGE_TAP0 + k))];
		end
		edge_sel[vblur_pkg::EDGE_ROWS-1] = px_s1;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			ctrl_s2 <= ctrl_s1;
			px_s2   <= px_s1;
			edge_s2 <= edge_sel;
		end
	end

	always_comb begin
		logic [vblur_pkg::ACC_W-1:0] sum;
		for (int g = 0; g < vblur_pkg::GROUPS; g++) begin
			for (int ch = 0; ch < vblur_pkg::CHANS; ch++) begin
				sum = '0;
				for (int j = 0; j < vblur_pkg::GROUP_LANES; j++) begin
					sum = sum + vblur_pkg::ACC_W'(prod_s2[g*vblur_pkg::GROUP_LANES + j][ch]);
				end
				part_sum[g][ch] = sum;
			end
		end
		// newest row, the last tap, joins the last group
		for (int ch = 0; ch < vblur_pkg::CHANS; ch++) begin
			part_sum[vblur_pkg::GROUPS-1][ch] = part_sum[vblur_pkg::GROUPS-1][ch]
				+ vblur_pkg::ACC_W'(px_s2[ch]) * vblur_pkg::ACC_W'(
					vblur_pkg::tap_weight(vblur_pkg::TAP_W'(vblur_pkg::TAPS - 1)));
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			ctrl_s3 <= ctrl_s2;
			edge_s3 <= edge_s2;
			part_s3 <= part_sum;
		end
	end

	always_comb begin
		for (int ch = 0; ch < vblur_pkg::CHANS; ch++) begin
			acc_sum[ch] = part_s3[0][ch] + part_s3[1][ch] + part_s3[2][ch];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			ctrl_s4 <= ctrl_s3;
			edge_s4 <= edge_s3;
			acc_s4  <= acc_sum;
		end
	end

	// divide by 246 through the reciprocal, exact for the accumulator range
	always_comb begin
		logic [PROD_SUM_W-1:0] full;
		for (int ch = 0; ch < vblur_pkg::CHANS; ch++) begin
			full = PROD_SUM_W'(acc_s4[ch]) * PROD_SUM_W'(vblur_pkg::RECIP);
			quot[ch] = full[vblur_pkg::RECIP_SHIFT +: vblur_pkg::CH_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			ctrl_s5 <= ctrl_s4;
			edge_s5 <= edge_s4;
			filt_s5 <= quot;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/vblur_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vblur_emit
// Output register: sends the one or seven beats of each item that has results.
// ----------------------------------------------------------------------------
module vblur_emit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  item_valid,
	input  wire vblur_pkg::ctrl_t                      ctrl_s5,
	input  wire vblur_pkg::pix_t                       filt_s5,
	input  wire vblur_pkg::pix_t [vblur_pkg::EDGE_ROWS-1:0] edge_s5,
	output logic                                       take,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output vblur_pkg::out_t                            out_data
);

	logic                          busy_q;
	logic [vblur_pkg::CNT_W-1:0]   idx_q;
	vblur_pkg::ctrl_t              ctrl_q;
	vblur_pkg::pix_t               filt_q;
	vblur_pkg::pix_t [vblur_pkg::EDGE_ROWS-1:0] edge_q;
	logic                          last_beat;
	logic [vblur_pkg::EDGE_W-1:0]  edge_idx;
	logic [vblur_pkg::ROW_W-1:0]   row;
	vblur_pkg::pix_t               pix;

	assign last_beat = (idx_q == ctrl_q.count - vblur_pkg::CNT_W'(1));
	assign take      = !busy_q || (out_ready && last_beat);
	assign out_valid = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (take) begin
			// items that cause no result are dropped here
			busy_q <= item_valid && (ctrl_s5.count != '0);
			idx_q  <= '0;
		end else if (out_ready) begin
			idx_q <= idx_q + vblur_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctrl_q <= ctrl_s5;
			filt_q <= filt_s5;
			edge_q <= edge_s5;
		end
	end

	assign edge_idx = vblur_pkg::EDGE_W'(idx_q - vblur_pkg::CNT_W'(1));

	always_comb begin
		if (idx_q == '0) begin
			// a top-row pass-through beat carries the incoming pixel
			pix = ctrl_q.pass ? edge_q[vblur_pkg::EDGE_ROWS-1] : filt_q;
		end else begin
			pix = edge_q[edge_idx];
		end
		row = ctrl_q.row_base + vblur_pkg::ROW_W'(idx_q);
	end

	always_comb begin
		out_data.red_out   = pix[0];
		out_data.green_out = pix[1];
		out_data.blue_out  = pix[2];
		out_data.out_row   = vblur_pkg::OUT_IDX_W'(row);
		out_data.out_col   = vblur_pkg::OUT_IDX_W'(ctrl_q.col);
		out_data.run_last  = last_beat;
	end

endmodule
`default_nettype wire

// ===== rtl/core/vertical_13tap_rgb_blur.sv =====
// A pixel's first result beat passes the pipeline registers and the output register.
// Throughput: one pixel per cycle unless the output is busy, set by the twelve banks
// read in parallel; a last-row pixel sends 7 beats (filtered row plus bottom rows).
// Reset: size registers return to 1024 x 512, the raster position to the start of a
// frame and the pipeline empties; the line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertical_13tap_rgb_blur
// Vertical 13-tap blur on a raster RGB stream, twelve row banks as lanes.
// ----------------------------------------------------------------------------
module vertical_13tap_rgb_blur (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire vblur_pkg::in_t                in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output vblur_pkg::out_t                    out_data,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [vblur_pkg::CFG_W-1:0]   cfg_data
);

	localparam int DIM_W = vblur_pkg::DIM_W;

	logic [vblur_pkg::CFG_W-1:0] width_q, height_q;
	logic [vblur_pkg::COL_W-1:0] col_q;
	logic [vblur_pkg::ROW_W-1:0] row_q;
	logic [vblur_pkg::TAP_W-1:0] phase_q;
	logic [DIM_W-1:0]            w_eff, h_eff;
	logic                        col_last, row_last, accept;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic free1, free2, free3, free4, free5;
	vblur_pkg::pipe_en_t en;

	vblur_pkg::pix_t  px_in, px_s1;
	vblur_pkg::ctrl_t ctrl_in, ctrl_s1, ctrl_s5;
	vblur_pkg::pix_t  [vblur_pkg::STORE_ROWS-1:0] bank_s1;
	vblur_pkg::prod_t [vblur_pkg::STORE_ROWS-1:0] prod_s2;
	vblur_pkg::pix_t  filt_s5;
	vblur_pkg::pix_t  [vblur_pkg::EDGE_ROWS-1:0] edge_s5;
	logic emit_take;

	// size registers; their effective values are clamped to the supported range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= vblur_pkg::WIDTH_RESET;
			height_q <= vblur_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				vblur_pkg::REG_WIDTH:  width_q  <= cfg_data;
				vblur_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (DIM_W'(width_q) > DIM_W'(vblur_pkg::MAX_WIDTH)) begin
			w_eff = DIM_W'(vblur_pkg::MAX_WIDTH);
		end else begin
			w_eff = DIM_W'(width_q);
		end
		if (DIM_W'(height_q) < DIM_W'(vblur_pkg::TAPS)) begin
			h_eff = DIM_W'(vblur_pkg::TAPS);
		end else if (DIM_W'(height_q) > DIM_W'(vblur_pkg::MAX_HEIGHT)) begin
			h_eff = DIM_W'(vblur_pkg::MAX_HEIGHT);
		end else begin
			h_eff = DIM_W'(height_q);
		end
	end

	assign col_last = (DIM_W'(col_q) + DIM_W'(1)) >= w_eff;
	assign row_last = (DIM_W'(row_q) + DIM_W'(1)) >= h_eff;
	assign accept   = in_valid && free1;

	// raster position; phase is the bank of the current row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			phase_q <= '0;
		end else if (cfg_we) begin
			col_q   <= '0;
			row_q   <= '0;
			phase_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				if (row_last) begin
					row_q   <= '0;
					phase_q <= '0;
				end else begin
					row_q <= row_q + vblur_pkg::ROW_W'(1);
					if (phase_q == vblur_pkg::TAP_W'(vblur_pkg::STORE_ROWS - 1)) begin
						phase_q <= '0;
					end else begin
						phase_q <= phase_q + vblur_pkg::TAP_W'(1);
					end
				end
			end else begin
				col_q <= col_q + vblur_pkg::COL_W'(1);
			end
		end
	end

	assign px_in = {in_data.blue_in, in_data.green_in, in_data.red_in};

	always_comb begin
		ctrl_in.pass  = row_q < vblur_pkg::ROW_W'(vblur_pkg::EDGE_ROWS);
		ctrl_in.col   = col_q;
		ctrl_in.phase = phase_q;
		if (ctrl_in.pass) begin
			ctrl_in.count    = vblur_pkg::CNT_W'(1);
			ctrl_in.row_base = row_q;
		end else begin
			ctrl_in.row_base = row_q - vblur_pkg::ROW_W'(vblur_pkg::EDGE_ROWS);
			if (row_q < vblur_pkg::ROW_W'(vblur_pkg::STORE_ROWS)) begin
				ctrl_in.count = '0;
			end else if (row_last) begin
				ctrl_in.count = vblur_pkg::CNT_W'(vblur_pkg::EDGE_ROWS + 1);
			end else begin
				ctrl_in.count = vblur_pkg::CNT_W'(1);
			end
		end
	end

	// stage k loads when it is empty or its beat moves on
	assign free5 = !valid_s5 || emit_take;
	assign free4 = !valid_s4 || free5;
	assign free3 = !valid_s3 || free4;
	assign free2 = !valid_s2 || free3;
	assign free1 = !valid_s1 || free2;
	assign in_ready = free1;

	assign en.s2 = free2;
	assign en.s3 = free3;
	assign en.s4 = free4;
	assign en.s5 = free5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (free1) valid_s1 <= in_valid;
			if (free2) valid_s2 <= valid_s1;
			if (free3) valid_s3 <= valid_s2;
			if (free4) valid_s4 <= valid_s3;
			if (free5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (free1) begin
			px_s1   <= px_in;
			ctrl_s1 <= ctrl_in;
		end
	end

	for (genvar b = 0; b < vblur_pkg::STORE_ROWS; b++) begin : g_lane
		vblur_lane u_lane (
			.clk        (clk),
			.rd_en      (free1),
			.wr_en      (accept && (phase_q == vblur_pkg::TAP_W'(b))),
			.addr       (col_q),
			.wr_data    (px_in),
			.prod_en    (free2),
			.tap        (vblur_pkg::bank_tap(ctrl_s1.phase, vblur_pkg::TAP_W'(b))),
			.rd_data_s1 (bank_s1[b]),
			.prod_s2    (prod_s2[b])
		);
	end

	vblur_merge u_merge (
		.clk     (clk),
		.en      (en),
		.ctrl_s1 (ctrl_s1),
		.px_s1   (px_s1),
		.bank_s1 (bank_s1),
		.prod_s2 (prod_s2),
		.ctrl_s5 (ctrl_s5),
		.filt_s5 (filt_s5),
		.edge_s5 (edge_s5)
	);

	vblur_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s5),
		.ctrl_s5    (ctrl_s5),
		.filt_s5    (filt_s5),
		.edge_s5    (edge_s5),
		.take       (emit_take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire

// ===== test/vertical_13tap_rgb_blur_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertical_13tap_rgb_blur_tb
// Streams raster RGB frames of many sizes through the vertical blur, with
// random gaps on the pixel side and random stalls on the result side, and
// compares every result beat against a line-store model kept in the bench.
// ----------------------------------------------------------------------------
module vertical_13tap_rgb_blur_tb;

	localparam int LINES      = 12;
	localparam int NTAPS      = 13;
	localparam int EDGE       = 6;
	localparam int NORM       = 246;
	localparam int MAX_W      = 2048;
	localparam int MAX_H      = 2048;
	localparam int DRAIN      = 24;
	localparam int HANG_LIMIT = 4000;
	localparam int ITEMS      = 500;
	localparam int unsigned TAP_WT [NTAPS] = '{3, 4, 6, 10, 20, 40, 80, 40, 20, 10, 6, 4, 3};

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_ready;
	vblur_pkg::in_t              in_data   = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	vblur_pkg::out_t             out_data;
	logic                        cfg_we    = 1'b0;
	logic                        cfg_index = 1'b0;
	logic [vblur_pkg::CFG_W-1:0] cfg_data  = '0;

	vertical_13tap_rgb_blur dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// bench copy of the block state
	vblur_pkg::pix_t             line_store [LINES][MAX_W];
	logic [vblur_pkg::CFG_W-1:0] width_reg  = 12'd1024;
	logic [vblur_pkg::CFG_W-1:0] height_reg = 12'd512;
	int unsigned                 col_pos    = 0;
	int unsigned                 row_pos    = 0;

	vblur_pkg::in_t  pixel_q [$];
	vblur_pkg::out_t blur_beats_q [$];

	int unsigned gap_max    = 0;
	int unsigned stall_max  = 0;
	int unsigned gap_left   = 0;
	int unsigned stall_left = 0;
	int unsigned fail_count = 0;
	int unsigned pix_count  = 0;
	int unsigned beat_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned phase_count = 0;

	function automatic int unsigned eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_W) return MAX_W;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg < NTAPS) return NTAPS;
		if (height_reg > MAX_H) return MAX_H;
		return height_reg;
	endfunction

	function automatic vblur_pkg::out_t make_beat(input vblur_pkg::pix_t p,
			input int unsigned row, input int unsigned col);
		vblur_pkg::out_t b;
		b.red_out   = p[0];
		b.green_out = p[1];
		b.blue_out  = p[2];
		b.out_row   = row[10:0];
		b.out_col   = col[10:0];
		b.run_last  = 1'b0;
		return b;
	endfunction

	// works out the beats one accepted pixel causes and advances the raster position
	task automatic blur_pixel(input vblur_pkg::in_t px_in);
		int unsigned w, h, c, r, n, row;
		int unsigned acc [3];
		vblur_pkg::pix_t px, tp, filt;
		vblur_pkg::out_t beats [7];
		w = eff_width();
		h = eff_height();
		c = (col_pos >= w) ? 0 : col_pos;
		r = (row_pos >= h) ? 0 : row_pos;
		n = 0;
		px[0] = px_in.red_in;
		px[1] = px_in.green_in;
		px[2] = px_in.blue_in;
		if (r < EDGE) begin
			beats[n] = make_beat(px, r, c);
			n++;
		end else if (r >= LINES) begin
			acc = '{0, 0, 0};
			for (int i = 0; i < NTAPS; i++) begin
				tp = (i < LINES) ? line_store[(r + i) % LINES][c] : px;
				for (int ch = 0; ch < 3; ch++) begin
					acc[ch] += TAP_WT[i] * tp[ch];
				end
			end
			for (int ch = 0; ch < 3; ch++) begin
				filt[ch] = 16'(acc[ch] / NORM);
			end
			beats[n] = make_beat(filt, r - EDGE, c);
			n++;
			// bottom row flushes the untouched rows of its column
			if (r == h - 1) begin
				for (int i = 0; i < EDGE - 1; i++) begin
					row = r - (EDGE - 1) + i;
					beats[n] = make_beat(line_store[row % LINES][c], row, c);
					n++;
				end
				beats[n] = make_beat(px, r, c);
				n++;
			end
		end
		line_store[r % LINES][c] = px;
		for (int i = 0; i < n; i++) begin
			if (i == n - 1) begin
				beats[i].run_last = 1'b1;
			end
			blur_beats_q.push_back(beats[i]);
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) begin
				r = 0;
			end
		end
		col_pos = c;
		row_pos = r;
	endtask

	// pixel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				blur_pixel(in_data);
				pix_count++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pixel_q.size() > 0) begin
					in_data  <= pixel_q.pop_front();
					in_valid <= 1'b1;
					gap_left = $urandom_range(0, gap_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		vblur_pkg::out_t got, want;
		logic bad;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = out_data;
				beat_count++;
				if (blur_beats_q.size() == 0) begin
					fail_count++;
					if (fail_count < 50) begin
						$error("result beat with nothing expected: row %0d col %0d",
							got.out_row, got.out_col);
					end
				end else begin
					want = blur_beats_q.pop_front();
					bad = 1'b0;
					if (fail_count < 50) begin
						if (got.red_out !== want.red_out) begin
							$error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
						end
						if (got.green_out !== want.green_out) begin
							$error("green_out: expected %0d, got %0d", want.green_out,
								got.green_out);
						end
						if (got.blue_out !== want.blue_out) begin
							$error("blue_out: expected %0d, got %0d", want.blue_out,
								got.blue_out);
						end
						if (got.out_row !== want.out_row) begin
							$error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
						end
						if (got.out_col !== want.out_col) begin
							$error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
						end
						if (got.run_last !== want.run_last) begin
							$error("run_last: expected %0d, got %0d", want.run_last,
								got.run_last);
						end
					end
					if (got !== want) begin
						bad = 1'b1;
					end
					if (bad) begin
						fail_count++;
					end
				end
				stall_left = $urandom_range(0, stall_max);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// hang detection: cycles with no beat on any port
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= HANG_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d results outstanding",
				HANG_LIMIT, blur_beats_q.size());
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(input logic idx, input int unsigned value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[vblur_pkg::CFG_W-1:0];
		if (idx == vblur_pkg::REG_WIDTH) begin
			width_reg = value[vblur_pkg::CFG_W-1:0];
		end else begin
			height_reg = value[vblur_pkg::CFG_W-1:0];
		end
		col_pos = 0;
		row_pos = 0;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold the stream until every pending pixel is in and every result is out;
	// checked on the falling edge so the driver's updates have settled
	task automatic settle();
		@(negedge clk);
		while (pixel_q.size() != 0 || in_valid || blur_beats_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic vblur_pkg::in_t rgb(input logic [15:0] r, input logic [15:0] g,
			input logic [15:0] b);
		vblur_pkg::in_t p;
		p.red_in   = r;
		p.green_in = g;
		p.blue_in  = b;
		return p;
	endfunction

	function automatic vblur_pkg::in_t rand_pixel();
		vblur_pkg::in_t p;
		case ($urandom_range(0, 7))
			0: p = rgb(16'hffff, 16'hffff, 16'hffff);
			1: p = rgb(16'h0000, 16'h0000, 16'h0000);
			2: p = rgb($urandom_range(0, 1) ? 16'hffff : 16'h0,
					$urandom_range(0, 1) ? 16'hffff : 16'h0,
					$urandom_range(0, 1) ? 16'hffff : 16'h0);
			default: p = rgb(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)));
		endcase
		return p;
	endfunction

	initial begin
		int unsigned w_val, h_val, ew, eh, frame, count, pause_at;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry, a few row-0 pixels with no idling
		pixel_q.push_back(rgb(16'hffff, 16'h0000, 16'h0000));
		pixel_q.push_back(rgb(16'h0000, 16'hffff, 16'h0000));
		pixel_q.push_back(rgb(16'h0000, 16'h0000, 16'hffff));
		pixel_q.push_back(rgb(16'haaaa, 16'h5555, 16'hffff));
		settle();

		// zero width acts as one, short height acts as thirteen: one full column,
		// edge rows, silent rows, a filtered row, the bottom flush, then a new frame
		write_reg(vblur_pkg::REG_WIDTH, 0);
		write_reg(vblur_pkg::REG_HEIGHT, 0);
		gap_max   = 3;
		stall_max = 3;
		pixel_q.push_back(rgb(16'h0000, 16'h0000, 16'h0000));
		for (int k = 1; k < 13; k++) begin
			pixel_q.push_back(rgb(16'hffff, (k % 2) ? 16'hffff : 16'h0000, 16'(1 << (k - 1))));
		end
		pixel_q.push_back(rgb(16'hffff, 16'hffff, 16'hffff));
		settle();

		// oversized registers clamp to the largest frame
		write_reg(vblur_pkg::REG_WIDTH, 4095);
		write_reg(vblur_pkg::REG_HEIGHT, 4095);
		for (int k = 0; k < 6; k++) begin
			pixel_q.push_back(rand_pixel());
		end
		settle();
		phase_count = 3;

		while (pix_count < ITEMS) begin
			case ($urandom_range(0, 9))
				0: w_val = 0;
				1: w_val = $urandom_range(2048, 4095);
				default: w_val = $urandom_range(1, 6);
			endcase
			case ($urandom_range(0, 9))
				0: h_val = $urandom_range(0, 13);
				1: h_val = $urandom_range(2048, 4095);
				default: h_val = $urandom_range(13, 18);
			endcase
			if ($urandom_range(0, 1)) begin
				write_reg(vblur_pkg::REG_WIDTH, w_val);
				write_reg(vblur_pkg::REG_HEIGHT, h_val);
			end else begin
				write_reg(vblur_pkg::REG_HEIGHT, h_val);
				write_reg(vblur_pkg::REG_WIDTH, w_val);
			end
			ew    = eff_width();
			eh    = eff_height();
			frame = ew * eh;
			// big frames only get a partial first rows run
			if (frame <= 160) begin
				count = frame * $urandom_range(1, 2) + $urandom_range(0, 2 * ew);
			end else begin
				count = $urandom_range(5, 40);
			end
			if (count > ITEMS - pix_count) begin
				count = ITEMS - pix_count;
			end
			gap_max   = $urandom_range(0, 2) ? 12 : 0;
			stall_max = $urandom_range(0, 2) ? 12 : 0;
			pause_at  = $urandom_range(0, 2) ? 0 : count / 2;
			for (int k = 0; k < count; k++) begin
				if (k == pause_at && k != 0) begin
					settle();
				end
				pixel_q.push_back(rand_pixel());
			end
			settle();
			phase_count++;
		end

		$display("%0d pixels sent over %0d geometry phases, %0d result beats checked",
			pix_count, phase_count, beat_count);
		$display("frames from 1 to 2048 columns and 13 to 2048 rows, edge, filtered and flush rows");
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
